>>> hw/rtl/touch_median_calibrate_defines.svh
// Assertion macros shared by the touch calibration block.
`ifndef TOUCH_MEDIAN_CALIBRATE_DEFINES_SVH
`define TOUCH_MEDIAN_CALIBRATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
`define TMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define TMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/tmc_pkg.sv
package tmc_pkg;

	localparam int RAW_W = 12;
	localparam int PIX_W = 9;
	localparam int IDX_W = 3;

	localparam logic [RAW_W-1:0] VALID_LOW_RST  = 12'd200;
	localparam logic [RAW_W-1:0] VALID_HIGH_RST = 12'd3900;
	localparam logic [RAW_W-1:0] RAW_MIN_RST    = 12'd300;
	localparam logic [RAW_W-1:0] RAW_MAX_RST    = 12'd3800;

	typedef enum logic [IDX_W-1:0] {
		REG_VALID_LOW  = 3'd0,
		REG_VALID_HIGH = 3'd1,
		REG_X_RAW_MIN  = 3'd2,
		REG_X_RAW_MAX  = 3'd3,
		REG_Y_RAW_MIN  = 3'd4,
		REG_Y_RAW_MAX  = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [RAW_W-1:0] num;
		logic [RAW_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic [RAW_W-1:0] median3(
		input logic [RAW_W-1:0] a,
		input logic [RAW_W-1:0] b,
		input logic [RAW_W-1:0] c
	);
		logic [RAW_W-1:0] lo;
		logic [RAW_W-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) begin
			return lo;
		end else if (c >= hi) begin
			return hi;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/touch_median_calibrate.sv
// Touch poll filter and calibration.
// The input stream carries one poll per word: three raw X and three raw Y
// conversions in s_tdata and the read-failed flag in s_tuser. The output
// stream carries one word per poll: screen column and row in m_tdata and
// the pressed flag in m_tuser. Calibration registers are written through
// cfg_we, cfg_index and cfg_data; the user must do so only while the block
// is idle, as the block itself does not enforce this. A released poll
// (failed read or a median outside the window) goes from idle straight to
// ST_FIN and from there into the output register. A pressed poll runs each
// axis through the shared scale-and-divide unit: set-up in ST_PREP and
// ST_MUL, one quotient bit per cycle while the divider is busy, and
// collection of the quotient in ST_WAIT; ST_FIN then loads the output
// register. An axis whose result is zero or clamped skips the divider and
// goes from ST_MUL on to the next axis or to ST_FIN.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new poll is taken while the last one waits; if the
// receiver still stalls when the next result is ready, the sequencer waits.
// Reset restores the default calibration and clears the held position.
`include "touch_median_calibrate_defines.svh"

module touch_median_calibrate import tmc_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c
	input  logic [71:0]      s_tdata,
	// read_failed
	input  logic [0:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// screen_x, screen_y, zero fill
	output logic [23:0]      m_tdata,
	// pressed
	output logic [0:0]       m_tuser,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [RAW_W-1:0] cfg_data
);

	localparam int MAX_SCALE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int QW        = $clog2(MAX_SCALE);
	localparam int SCW       = $clog2(MAX_SCALE + 1);

	logic [RAW_W-1:0] valid_low_q;
	logic [RAW_W-1:0] valid_high_q;
	logic [RAW_W-1:0] x_raw_min_q;
	logic [RAW_W-1:0] x_raw_max_q;
	logic [RAW_W-1:0] y_raw_min_q;
	logic [RAW_W-1:0] y_raw_max_q;

	state_t           state_q;
	state_t           state_d;
	logic             axis_q;
	logic [RAW_W-1:0] mx_q;
	logic [RAW_W-1:0] my_q;
	logic             ok_q;
	logic [RAW_W-1:0] num_mag_q;
	logic [RAW_W-1:0] den_mag_q;
	logic             byp_q;
	logic [QW-1:0]    byp_val_q;
	logic [PIX_W-1:0] held_x_q;
	logic [PIX_W-1:0] held_y_q;
	logic             m_tvalid_q;
	logic [23:0]      m_tdata_q;
	logic             m_tuser_q;

	logic [RAW_W-1:0] mx;
	logic [RAW_W-1:0] my;
	logic             ok;
	logic             accept;
	logic             out_free;
	logic [RAW_W:0]   num_s;
	logic [RAW_W:0]   span_s;
	logic [RAW_W:0]   num_abs;
	logic [RAW_W:0]   span_abs;
	logic [RAW_W-1:0] num_mag;
	logic [RAW_W-1:0] span_mag;
	logic             to_zero;
	logic             to_clamp;
	logic [QW-1:0]    clamp_val;
	logic [SCW-1:0]   scale;
	logic             res_take;
	logic [QW-1:0]    res_val;
	logic             fin_load;

	div_req_t         div_req;
	div_sts_t         div_sts;
	logic [QW-1:0]    div_quo;

	assign mx = median3(s_tdata[11:0], s_tdata[23:12], s_tdata[35:24]);
	assign my = median3(s_tdata[47:36], s_tdata[59:48], s_tdata[71:60]);
	assign ok = !s_tuser[0] && (mx >= valid_low_q) && (mx <= valid_high_q)
		&& (my >= valid_low_q) && (my <= valid_high_q);

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		if (axis_q) begin
			num_s     = {1'b0, y_raw_max_q} - {1'b0, my_q};
			span_s    = {1'b0, y_raw_max_q} - {1'b0, y_raw_min_q};
			clamp_val = QW'(SCREEN_HEIGHT - 1);
			scale     = SCW'(SCREEN_HEIGHT);
		end else begin
			num_s     = {1'b0, mx_q} - {1'b0, x_raw_min_q};
			span_s    = {1'b0, x_raw_max_q} - {1'b0, x_raw_min_q};
			clamp_val = QW'(SCREEN_WIDTH - 1);
			scale     = SCW'(SCREEN_WIDTH);
		end
		num_abs  = num_s[RAW_W] ? ({(RAW_W+1){1'b0}} - num_s) : num_s;
		span_abs = span_s[RAW_W] ? ({(RAW_W+1){1'b0}} - span_s) : span_s;
		num_mag  = num_abs[RAW_W-1:0];
		span_mag = span_abs[RAW_W-1:0];
		to_zero  = (span_mag == '0) || (num_mag == '0) || (num_s[RAW_W] != span_s[RAW_W]);
		to_clamp = num_mag >= span_mag;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ok ? ST_PREP : ST_FIN;
				end
			end
			ST_PREP: state_d = ST_MUL;
			ST_MUL: begin
				if (byp_q) begin
					state_d = axis_q ? ST_FIN : ST_PREP;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (div_sts.done) begin
					state_d = axis_q ? ST_FIN : ST_PREP;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = num_mag_q;
		div_req.den   = den_mag_q;
		res_take      = 1'b0;
		res_val       = byp_val_q;
		fin_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_PREP: ;
			ST_MUL: begin
				div_req.start = !byp_q;
				res_take      = byp_q;
			end
			ST_WAIT: begin
				res_take = div_sts.done;
				res_val  = div_quo;
			end
			ST_FIN: fin_load = out_free;
			default: ;
		endcase
	end

	tmc_div #(
		.QW  (QW),
		.SCW (SCW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.scale  (scale),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_low_q  <= VALID_LOW_RST;
			valid_high_q <= VALID_HIGH_RST;
			x_raw_min_q  <= RAW_MIN_RST;
			x_raw_max_q  <= RAW_MAX_RST;
			y_raw_min_q  <= RAW_MIN_RST;
			y_raw_max_q  <= RAW_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VALID_LOW:  valid_low_q  <= cfg_data;
				REG_VALID_HIGH: valid_high_q <= cfg_data;
				REG_X_RAW_MIN:  x_raw_min_q  <= cfg_data;
				REG_X_RAW_MAX:  x_raw_max_q  <= cfg_data;
				REG_Y_RAW_MIN:  y_raw_min_q  <= cfg_data;
				REG_Y_RAW_MAX:  y_raw_max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= 1'b0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				axis_q <= 1'b0;
			end else if (res_take) begin
				axis_q <= 1'b1;
			end
			if (res_take) begin
				if (axis_q) begin
					held_y_q <= PIX_W'(res_val);
				end else begin
					held_x_q <= PIX_W'(res_val);
				end
			end
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q <= mx;
			my_q <= my;
			ok_q <= ok;
		end
		if (state_q == ST_PREP) begin
			num_mag_q <= num_mag;
			den_mag_q <= span_mag;
			byp_q     <= to_zero || to_clamp;
			byp_val_q <= to_zero ? '0 : clamp_val;
		end
		if (fin_load) begin
			m_tdata_q <= {6'd0, held_y_q, held_x_q};
			m_tuser_q <= ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`TMC_ASSERT_IMPLY(a_idle_div_quiet, clk, arst_n, state_q == ST_IDLE, !div_sts.busy)
	`TMC_ASSERT_IMPLY(a_done_in_wait, clk, arst_n, div_sts.done, state_q == ST_WAIT)
	`TMC_ASSERT_NEXT(a_fail_skips, clk, arst_n, accept && s_tuser[0], state_q == ST_FIN)

endmodule

>>> hw/rtl/tmc_div.sv
module tmc_div import tmc_pkg::*; #(
	parameter int QW  = 9,
	parameter int SCW = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  div_req_t       req,
	input  logic [SCW-1:0] scale,
	output div_sts_t       sts,
	output logic [QW-1:0]  quo
);

	localparam int PW = RAW_W + SCW;
	localparam int CW = $clog2(QW + 1);

	logic [PW-1:0]    prod;
	logic [RAW_W-1:0] rem_q;
	logic [QW-1:0]    low_q;
	logic [RAW_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RAW_W:0]   shifted;
	logic [RAW_W:0]   diff;
	logic             qbit;
	logic [RAW_W-1:0] rem_d;
	logic [QW:0]      low_ext;

	assign prod = PW'(req.num) * PW'(scale);

	always_comb begin
		shifted = {rem_q, low_q[QW-1]};
		diff    = shifted - {1'b0, den_q};
		qbit    = ~diff[RAW_W];
		rem_d   = qbit ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
		low_ext = {low_q, qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= prod[QW +: RAW_W];
			low_q <= prod[QW-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_d;
			low_q <= low_ext[QW-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = low_q;

endmodule

>>> test/tb_top.sv
module tb_top;
	import tmc_pkg::*;

	localparam int SCR_W = 320;
	localparam int SCR_H = 480;
	localparam int STALL_MAX = 13;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POLLS = 105;
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [RAW_W-1:0] xa;
		logic [RAW_W-1:0] xb;
		logic [RAW_W-1:0] xc;
		logic [RAW_W-1:0] ya;
		logic [RAW_W-1:0] yb;
		logic [RAW_W-1:0] yc;
		logic             failed;
	} poll_t;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             pressed;
	} touch_t;

	typedef struct packed {
		poll_t  poll;
		logic   typed;
		touch_t want;
	} row_t;

	localparam int ROWS = 18;

	// Rows with a typed result assume the default calibration after reset.
	localparam row_t DIRECTED [ROWS] = '{
		'{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b1, '{9'd0, 9'd0, 1'b0}},
		'{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0}, 1'b1,
			'{9'd0, 9'd0, 1'b0}},
		'{'{12'd300, 12'd4095, 12'd0, 12'd3800, 12'd0, 12'd4095, 1'b0}, 1'b1,
			'{9'd0, 9'd0, 1'b1}},
		'{'{12'd0, 12'd3800, 12'd4095, 12'd300, 12'd300, 12'd300, 1'b0}, 1'b1,
			'{9'd319, 9'd479, 1'b1}},
		'{'{12'd2000, 12'd2000, 12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b1}, 1'b1,
			'{9'd319, 9'd479, 1'b0}},
		'{'{12'd200, 12'd100, 12'd3000, 12'd4000, 12'd3900, 12'd0, 1'b0}, 1'b1,
			'{9'd0, 9'd0, 1'b1}},
		'{'{12'd3900, 12'd3950, 12'd10, 12'd200, 12'd50, 12'd201, 1'b0}, 1'b1,
			'{9'd319, 9'd479, 1'b1}},
		'{'{12'd199, 12'd199, 12'd4095, 12'd2000, 12'd2000, 12'd2000, 1'b0}, 1'b1,
			'{9'd319, 9'd479, 1'b0}},
		'{'{12'd2000, 12'd2000, 12'd2000, 12'd3901, 12'd3901, 12'd0, 1'b0}, 1'b1,
			'{9'd319, 9'd479, 1'b0}},
		'{'{12'd1000, 12'd2000, 12'd3000, 12'd3000, 12'd2000, 12'd1000, 1'b0}, 1'b0, '0},
		'{'{12'd3000, 12'd1000, 12'd2000, 12'd1500, 12'd2500, 12'd500, 1'b0}, 1'b0, '0},
		'{'{12'd1234, 12'd1234, 12'd3500, 12'd2222, 12'd3333, 12'd3333, 1'b0}, 1'b0, '0},
		'{'{12'hAAA, 12'h555, 12'hFFF, 12'h555, 12'hAAA, 12'h000, 1'b0}, 1'b0, '0},
		'{'{12'hAAA, 12'h555, 12'hFFF, 12'h555, 12'hAAA, 12'h000, 1'b1}, 1'b0, '0},
		'{'{12'd2049, 12'd2047, 12'd2048, 12'd1024, 12'd3072, 12'd2048, 1'b0}, 1'b0, '0},
		'{'{12'd301, 12'd302, 12'd303, 12'd3799, 12'd3798, 12'd3797, 1'b0}, 1'b0, '0},
		'{'{12'd3799, 12'd3799, 12'd3799, 12'd301, 12'd301, 12'd301, 1'b0}, 1'b0, '0},
		'{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [71:0]      s_tdata = '0;
	logic [0:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;
	logic [0:0]       m_tuser;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [RAW_W-1:0] cfg_data = '0;

	logic [RAW_W-1:0] lim_low = VALID_LOW_RST;
	logic [RAW_W-1:0] lim_high = VALID_HIGH_RST;
	logic [RAW_W-1:0] x_min = RAW_MIN_RST;
	logic [RAW_W-1:0] x_max = RAW_MAX_RST;
	logic [RAW_W-1:0] y_min = RAW_MIN_RST;
	logic [RAW_W-1:0] y_max = RAW_MAX_RST;
	logic [PIX_W-1:0] held_x = '0;
	logic [PIX_W-1:0] held_y = '0;

	touch_t pending_touch [$];
	int     errors = 0;
	int     quiet = 0;
	int     next_gap = 0;
	int     polls_sent = 0;
	int     words_taken = 0;
	int     stall_left = 0;
	int     stall_draw;
	bit     send_calm = 1'b0;
	bit     take_calm = 1'b0;

	touch_median_calibrate #(
		.SCREEN_WIDTH (SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int gap_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, STALL_MAX);
	endfunction

	function automatic int median_of(input int a, input int b, input int c);
		int top;
		int bottom;
		top = (a > b) ? a : b;
		top = (top > c) ? top : c;
		bottom = (a < b) ? a : b;
		bottom = (bottom < c) ? bottom : c;
		return a + b + c - top - bottom;
	endfunction

	function automatic logic [PIX_W-1:0] to_pixel(input longint num, input longint span,
			input longint full);
		longint v;
		if (span == 0) begin
			return '0;
		end
		v = (num * full) / span;
		if (v < 0) begin
			v = 0;
		end
		if (v >= full) begin
			v = full - 1;
		end
		return v[PIX_W-1:0];
	endfunction

	function automatic touch_t predict_touch(input poll_t p);
		int     mx;
		int     my;
		logic   ok;
		longint lo;
		longint hi;
		touch_t t;
		mx = median_of(p.xa, p.xb, p.xc);
		my = median_of(p.ya, p.yb, p.yc);
		lo = lim_low;
		hi = lim_high;
		ok = !p.failed && mx >= lo && mx <= hi && my >= lo && my <= hi;
		if (ok) begin
			held_x = to_pixel(longint'(mx) - longint'(x_min),
				longint'(x_max) - longint'(x_min), SCR_W);
			held_y = to_pixel(longint'(y_max) - longint'(my),
				longint'(y_max) - longint'(y_min), SCR_H);
		end
		t.x = held_x;
		t.y = held_y;
		t.pressed = ok;
		return t;
	endfunction

	function automatic int in_window();
		return $urandom_range(lim_low, lim_high);
	endfunction

	function automatic int near_edge();
		case ($urandom_range(0, 3))
			0: return lim_low;
			1: return lim_high;
			2: return (lim_low == 0) ? 0 : lim_low - 1;
			default: return (lim_high == 12'hFFF) ? 12'hFFF : lim_high + 1;
		endcase
	endfunction

	// Three samples whose median is m, in any order.
	function automatic logic [3*RAW_W-1:0] spread3(input int m);
		logic [RAW_W-1:0] a;
		logic [RAW_W-1:0] b;
		logic [RAW_W-1:0] c;
		a = RAW_W'(m);
		b = RAW_W'($urandom_range(0, m));
		c = RAW_W'($urandom_range(m, 4095));
		if ($urandom_range(0, 3) == 0) begin
			b = a;
		end
		case ($urandom_range(0, 5))
			0: return {a, b, c};
			1: return {a, c, b};
			2: return {b, a, c};
			3: return {b, c, a};
			4: return {c, a, b};
			default: return {c, b, a};
		endcase
	endfunction

	function automatic poll_t random_poll();
		poll_t p;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 15 || lim_low > lim_high) begin
			{p.xa, p.xb, p.xc, p.ya, p.yb, p.yc} = 72'({$urandom, $urandom, $urandom});
		end else begin
			{p.xa, p.xb, p.xc} = spread3((pick < 30) ? near_edge() : in_window());
			{p.ya, p.yb, p.yc} = spread3((pick >= 22 && pick < 37) ? near_edge() : in_window());
		end
		p.failed = ($urandom_range(0, 9) == 0);
		return p;
	endfunction

	task automatic report(input string field, input int got, input int want_v);
		$display("%0t: %s is %0d, should be %0d", $time, field, got, want_v);
		errors++;
	endtask

	task automatic check_word(input logic [23:0] data, input logic pressed);
		touch_t want;
		if (pending_touch.size() == 0) begin
			report("unexpected word, column", data[8:0], -1);
			return;
		end
		want = pending_touch.pop_front();
		if (data[8:0] != want.x) begin
			report("screen_x", data[8:0], want.x);
		end
		if (data[17:9] != want.y) begin
			report("screen_y", data[17:9], want.y);
		end
		if (pressed != want.pressed) begin
			report("pressed", pressed, want.pressed);
		end
		if (data[23:18] != '0) begin
			report("zero fill", data[23:18], 0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_word(m_tdata, m_tuser[0]);
				words_taken++;
				if (words_taken % 40 == 0) begin
					take_calm = ($urandom_range(0, 3) == 0);
				end
				stall_draw = gap_draw(take_calm);
				m_tready <= (stall_draw == 0);
				stall_left <= stall_draw;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= (stall_left == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_poll(input poll_t p, input logic typed, input touch_t want,
			input bit more);
		touch_t predicted;
		repeat (next_gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {p.yc, p.yb, p.ya, p.xc, p.xb, p.xa};
		s_tuser <= p.failed;
		do begin
			@(posedge clk);
		end while (!s_tready);
		predicted = predict_touch(p);
		pending_touch.push_back(typed ? want : predicted);
		polls_sent++;
		if (polls_sent % 40 == 0) begin
			send_calm = ($urandom_range(0, 3) == 0);
		end
		next_gap = gap_draw(send_calm);
		if (!more || next_gap != 0) begin
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pending_touch.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_VALID_LOW: lim_low = val;
			REG_VALID_HIGH: lim_high = val;
			REG_X_RAW_MIN: x_min = val;
			REG_X_RAW_MAX: x_max = val;
			REG_Y_RAW_MIN: y_min = val;
			REG_Y_RAW_MAX: y_max = val;
			default: ;
		endcase
	endtask

	task automatic run_random(input int count);
		bit pause;
		for (int i = 0; i < count; i++) begin
			pause = ($urandom_range(0, 59) == 0);
			send_poll(random_poll(), 1'b0, '0, (i != count - 1) && !pause);
			if (pause) begin
				wait_drained();
			end
		end
	endtask

	task automatic run_phase(input logic [RAW_W-1:0] vl, input logic [RAW_W-1:0] vh,
			input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] xh,
			input logic [RAW_W-1:0] yl, input logic [RAW_W-1:0] yh, input int count);
		wait_drained();
		put_reg(REG_SPARE_A, RAW_W'($urandom_range(0, 4095)));
		put_reg(REG_VALID_LOW, vl);
		put_reg(REG_VALID_HIGH, vh);
		put_reg(REG_X_RAW_MIN, xl);
		put_reg(REG_X_RAW_MAX, xh);
		put_reg(REG_Y_RAW_MIN, yl);
		put_reg(REG_Y_RAW_MAX, yh);
		put_reg(REG_SPARE_B, RAW_W'($urandom_range(0, 4095)));
		cfg_we <= 1'b0;
		run_random(count);
	endtask

	initial begin
		int lo;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < ROWS; i++) begin
			send_poll(DIRECTED[i].poll, DIRECTED[i].typed, DIRECTED[i].want, 1'b1);
		end
		run_random(PHASE_POLLS);
		run_phase(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, PHASE_POLLS);
		run_phase(12'd0, 12'd4095, 12'd2048, 12'd2048, 12'd1000, 12'd1000, PHASE_POLLS);
		run_phase(12'd100, 12'd4000, 12'd3800, 12'd300, 12'd4095, 12'd0, PHASE_POLLS);
		run_phase(12'd4095, 12'd0, 12'd300, 12'd3800, 12'd300, 12'd3800, 40);
		run_phase(12'd1500, 12'd1600, 12'd1400, 12'd1700, 12'd1450, 12'd1650, PHASE_POLLS);
		repeat (2) begin
			lo = $urandom_range(0, 2000);
			run_phase(RAW_W'(lo), RAW_W'($urandom_range(lo, 4095)),
				RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)),
				RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)),
				PHASE_POLLS);
		end
		run_phase(VALID_LOW_RST, VALID_HIGH_RST, RAW_MIN_RST, RAW_MAX_RST, RAW_MIN_RST,
			RAW_MAX_RST, PHASE_POLLS);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending_touch.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
